[src/tfwc_pkg.sv]
// shared types and constants for the table feedback word cipher
package tfwc_pkg;

    localparam int WordW      = 32;
    localparam int AddrW      = 9;
    localparam int TableDepth = 257;
    localparam int NumRegs    = 8;
    localparam int RegIdxW    = 3;

    typedef enum logic [1:0] {
        CMD_BUILD   = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2
    } cmd_t;

    localparam logic [RegIdxW-1:0] REG_TABLE_KEY_0  = 3'd0;
    localparam logic [RegIdxW-1:0] REG_CHAIN_SEED_0 = 3'd4;

    localparam logic [WordW-1:0] LOW24    = 32'h00ffffff;
    localparam logic [WordW-1:0] ACC_MASK = 32'hff7fffff;
    localparam logic [WordW-1:0] Z_SET    = 32'h01000001;

    localparam logic [7:0]       P_ACC_SRC  = 8'd33;
    localparam logic [7:0]       P_Z_SRC    = 8'd59;
    localparam logic [7:0]       MIX_COUNT  = 8'd23;
    localparam logic [7:0]       FILL_SEEDS = 8'd4;
    localparam logic [AddrW-1:0] MIX_OFFSET = 9'd89;
    localparam logic [AddrW-1:0] LAST_ENTRY = 9'd256;

    localparam logic [WordW-1:0] FILL_CONSTS [8] = '{
        32'h726a8f3b, 32'he69a3b5c, 32'hd3c71fe5, 32'hab3c73d2,
        32'h4d3a8eb3, 32'h0396d6e8, 32'h3d4c2f7a, 32'h9ee27cf3
    };

    typedef struct packed {
        logic [1:0]       command;
        logic [WordW-1:0] word_in;
        logic             first_word;
    } item_t;

    typedef struct packed {
        logic [WordW-1:0] word_out;
        logic [WordW-1:0] chain_a;
        logic [WordW-1:0] chain_b;
        logic [WordW-1:0] chain_c;
        logic [WordW-1:0] chain_d;
        logic             not_ready;
    } result_t;

    typedef struct packed {
        logic [AddrW-1:0] rd_addr_a;
        logic [AddrW-1:0] rd_addr_b;
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        logic [WordW-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } build_status_t;

endpackage

[src/table_feedback_word_cipher.sv]
// table feedback word cipher top level: control, chain datapath, result register
//
// item channel (item_valid, item_stall, item) takes one command per transfer:
// build table, encrypt word or decrypt word. result channel (result_valid,
// result_stall, result) returns exactly one result per item, in order.
// configuration: cfg_write with cfg_index 0..3 writes the table keys,
// 4..7 the chain seeds; write only while no item is in flight.
// a build walks the 257-entry table memory: a fill pass writes entries
// 0..255, a mix and top-byte pass rewrites each of them, one tail write
// sets entry 256, then a permutation pass runs over entries 0..255.
// an encrypt or decrypt word makes four dependent lookups through the
// registered table read port before its result reaches the result register;
// the next item is taken only once that result is loaded.
// cipher items before any build, and unused commands, skip the lookups and
// go from transfer straight to the output state.
// reset clears keys, seeds, chain words and the built flag; the table
// memory holds garbage until the first build.
// a stalled result sits in the output register; the next item is taken
// meanwhile and waits only if it finishes before that result is taken.
module table_feedback_word_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  tfwc_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tfwc_pkg::result_t                   result,
    input  logic                                cfg_write,
    input  logic [tfwc_pkg::RegIdxW-1:0]        cfg_index,
    input  logic [tfwc_pkg::WordW-1:0]          cfg_data
);
    import tfwc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BUILD = 7'b0000010,
        S_C1    = 7'b0000100,
        S_C2    = 7'b0001000,
        S_C3    = 7'b0010000,
        S_C4    = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [3:0][WordW-1:0] key_reg;
    logic [3:0][WordW-1:0] seed_reg;
    logic [3:0][WordW-1:0] chain_reg, chain_next, chain_eff;
    logic                  built_reg, built_next;
    logic [WordW-1:0]      r_reg, r_next;
    logic [WordW-1:0]      result_word_reg, result_word_next;
    logic                  nr_reg, nr_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               result_reg, result_next;
    logic                  out_free, out_load, build_start;

    logic [WordW-1:0]      rd_a, rd_b, step_word;
    mem_req_t              build_req, cipher_req, mem_req;
    build_status_t         build_status;

    tfwc_build u_build (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (build_start),
        .keys   (key_reg),
        .rd_a   (rd_a),
        .rd_b   (rd_b),
        .req    (build_req),
        .status (build_status)
    );

    tfwc_table_mem u_mem (
        .clk  (clk),
        .req  (mem_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    assign cipher_req = '{rd_addr_a: {1'b0, r_next[7:0]}, rd_addr_b: {1'b0, r_next[7:0]},
                          wr_en: 1'b0, wr_addr: '0, wr_data: '0};
    assign mem_req    = build_status.busy ? build_req : cipher_req;

    assign step_word  = {8'd0, r_reg[WordW-1:8]} ^ rd_a;
    assign chain_eff  = item.first_word ? seed_reg : chain_reg;

    assign item_stall   = state_reg != S_IDLE;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    assign result_next = '{word_out: result_word_reg, chain_a: chain_next[0],
                           chain_b: chain_next[1], chain_c: chain_next[2],
                           chain_d: chain_next[3], not_ready: nr_reg};
    assign out_valid_next = out_load || (out_valid_reg && result_stall);

    always_comb
    begin
        state_next       = state_reg;
        chain_next       = chain_reg;
        built_next       = built_reg;
        r_next           = r_reg;
        result_word_next = result_word_reg;
        nr_next          = nr_reg;
        out_load         = 1'b0;
        build_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.command) inside
                        CMD_BUILD:
                        begin
                            build_start      = 1'b1;
                            result_word_next = '0;
                            nr_next          = 1'b0;
                            state_next       = S_BUILD;
                        end
                        CMD_ENCRYPT, CMD_DECRYPT:
                        begin
                            if (built_reg)
                            begin
                                chain_next       = chain_eff;
                                result_word_next = item.word_in ^ chain_eff[3];
                                r_next           = chain_eff[0]
                                                 + ((item.command == CMD_ENCRYPT)
                                                    ? result_word_next : item.word_in);
                                nr_next          = 1'b0;
                                state_next       = S_C1;
                            end
                            else
                            begin
                                result_word_next = '0;
                                nr_next          = 1'b1;
                                state_next       = S_OUT;
                            end
                        end
                        default:
                        begin
                            result_word_next = '0;
                            nr_next          = 1'b0;
                            state_next       = S_OUT;
                        end
                    endcase
                end
            end
            S_BUILD:
            begin
                if (build_status.done)
                begin
                    built_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_C1:
            begin
                chain_next[0] = step_word;
                r_next        = chain_reg[1] + step_word;
                state_next    = S_C2;
            end
            S_C2:
            begin
                chain_next[1] = step_word;
                r_next        = chain_reg[2] + step_word;
                state_next    = S_C3;
            end
            S_C3:
            begin
                chain_next[2] = step_word;
                r_next        = chain_reg[3] + step_word;
                state_next    = S_C4;
            end
            S_C4:
            begin
                chain_next[3] = step_word;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chain_reg     <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (cfg_index < REG_CHAIN_SEED_0)
                begin
                    key_reg[cfg_index[1:0] - REG_TABLE_KEY_0[1:0]] <= cfg_data;
                end
                else
                begin
                    seed_reg[cfg_index[1:0]] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg           <= r_next;
        result_word_reg <= result_word_next;
        nr_reg          <= nr_next;
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    // build sequencer runs exactly while the control sits in the build state
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD) == build_status.busy)
        else $error("build sequencer activity out of step with control state");

    // only the build sequencer writes the table
    a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == S_BUILD))
        else $error("table written outside a build");

    // chain steps only run on a built table
    a_chain_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C1 || state_reg == S_C2 || state_reg == S_C3 || state_reg == S_C4)
        |-> built_reg)
        else $error("chain step on a table that was never built");

    // a transfer leaves the idle state at the next edge
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

endmodule

[src/tfwc_table_mem.sv]
// key table memory: one write port, two registered read ports
module tfwc_table_mem (
    input  logic                        clk,
    input  tfwc_pkg::mem_req_t          req,
    output logic [tfwc_pkg::WordW-1:0]  rd_a,
    output logic [tfwc_pkg::WordW-1:0]  rd_b
);
    import tfwc_pkg::*;

    logic [WordW-1:0] mem [TableDepth];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_a <= mem[req.rd_addr_a];
        rd_b <= mem[req.rd_addr_b];
    end

endmodule

[src/tfwc_build.sv]
// table build sequencer: fill, mix and top-byte pass, tail write, permutation pass
module tfwc_build (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [3:0][tfwc_pkg::WordW-1:0]      keys,
    input  logic [tfwc_pkg::WordW-1:0]           rd_a,
    input  logic [tfwc_pkg::WordW-1:0]           rd_b,
    output tfwc_pkg::mem_req_t                   req,
    output tfwc_pkg::build_status_t              status
);
    import tfwc_pkg::*;

    typedef enum logic [8:0] {
        B_IDLE     = 9'b000000001,
        B_FILL     = 9'b000000010,
        B_MIX_RD   = 9'b000000100,
        B_MIX_WR   = 9'b000001000,
        B_TAIL     = 9'b000010000,
        B_PERM_RD0 = 9'b000100000,
        B_PERM_RD1 = 9'b001000000,
        B_PERM_WR0 = 9'b010000000,
        B_PERM_WR1 = 9'b100000000
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [7:0]       p_reg, p_next;
    logic [7:0]       y_reg, y_next;
    logic [3:0][WordW-1:0] win_reg, win_next;
    logic [WordW-1:0] acc_reg, acc_next;
    logic [WordW-1:0] z_reg, z_next;
    logic [WordW-1:0] t0_reg, t0_next;
    logic [WordW-1:0] tp1_reg, tp1_next;

    logic [WordW-1:0] fill_sum, fill_word, mix_word, acc_step, top_word;
    logic [7:0]       y_new;
    logic             mix_hit, p_last;

    assign fill_sum  = win_reg[0] + win_reg[3];
    assign fill_word = (p_reg < FILL_SEEDS) ? keys[p_reg[1:0]]
                     : ((fill_sum >> 3) ^ FILL_CONSTS[fill_sum[2:0]]);
    assign mix_hit   = p_reg < MIX_COUNT;
    assign mix_word  = rd_a + (mix_hit ? rd_b : '0);
    assign acc_step  = (acc_reg & ACC_MASK) + z_reg;
    assign top_word  = (mix_word & LOW24) ^ acc_step;
    assign y_new     = rd_a[7:0] ^ y_reg;
    assign p_last    = p_reg == 8'hff;

    assign status.busy = state_reg != B_IDLE;
    assign status.done = (state_reg == B_PERM_WR1) && p_last;

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        y_next     = y_reg;
        win_next   = win_reg;
        acc_next   = acc_reg;
        z_next     = z_reg;
        t0_next    = t0_reg;
        tp1_next   = tp1_reg;

        req.rd_addr_a = {1'b0, p_reg};
        req.rd_addr_b = mix_hit ? ({1'b0, p_reg} + MIX_OFFSET) : {1'b0, p_reg};
        req.wr_en     = 1'b0;
        req.wr_addr   = {1'b0, p_reg};
        req.wr_data   = fill_word;

        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    p_next     = '0;
                    state_next = B_FILL;
                end
            end
            B_FILL:
            begin
                req.wr_en = 1'b1;
                win_next  = {fill_word, win_reg[3], win_reg[2], win_reg[1]};
                if (p_reg == P_ACC_SRC)
                begin
                    acc_next = fill_word;
                end
                if (p_reg == P_Z_SRC)
                begin
                    z_next = (fill_word | Z_SET) & ACC_MASK;
                end
                p_next = p_reg + 8'd1;
                if (p_last)
                begin
                    state_next = B_MIX_RD;
                end
            end
            B_MIX_RD:
            begin
                state_next = B_MIX_WR;
            end
            B_MIX_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_data = top_word;
                acc_next    = acc_step;
                if (p_reg == 8'd0)
                begin
                    t0_next = top_word;
                end
                p_next     = p_reg + 8'd1;
                state_next = p_last ? B_TAIL : B_MIX_RD;
            end
            B_TAIL:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = LAST_ENTRY;
                req.wr_data = t0_reg;
                y_next      = acc_reg[7:0];
                p_next      = '0;
                state_next  = B_PERM_RD0;
            end
            B_PERM_RD0:
            begin
                req.rd_addr_a = {1'b0, p_reg ^ y_reg};
                state_next    = B_PERM_RD1;
            end
            B_PERM_RD1:
            begin
                y_next        = y_new;
                req.rd_addr_a = {1'b0, y_new};
                req.rd_addr_b = {1'b0, p_reg} + 9'd1;
                state_next    = B_PERM_WR0;
            end
            B_PERM_WR0:
            begin
                req.wr_en   = 1'b1;
                req.wr_data = rd_a;
                tp1_next    = rd_b;
                state_next  = B_PERM_WR1;
            end
            B_PERM_WR1:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = {1'b0, y_reg};
                req.wr_data = tp1_reg;
                p_next      = p_reg + 8'd1;
                state_next  = p_last ? B_IDLE : B_PERM_RD0;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        win_reg <= win_next;
        acc_reg <= acc_next;
        z_reg   <= z_next;
        t0_reg  <= t0_next;
        tp1_reg <= tp1_next;
    end

endmodule
